// File: rtl/euler_rotate_grid_points_defines.svh
// Assertion helpers shared by the RTL. Each one samples at the rising edge of clk
// and is switched off while rst is high.
`ifndef EULER_ROTATE_GRID_POINTS_DEFINES_SVH
`define EULER_ROTATE_GRID_POINTS_DEFINES_SVH

// The rule must hold in the same cycle as the condition.
`define ERGP_ASSERT_NOW(lbl, cond, rule, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (rule)) else $error(msg);

// The rule must hold in the cycle after the condition.
`define ERGP_ASSERT_NEXT(lbl, cond, rule, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (rule)) else $error(msg);

`endif

// File: rtl/ergp_pkg.sv
package ergp_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPACING  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HSCALE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS  = 3'd5;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  // Largest grid index that is still transformed is MAX_POINTS - 1.
  localparam logic [24:0] MAX_POINTS = 25'd65536;

  localparam int DIV_STAGES = 16;

  // Sine table entries are wide enough for the finest supported trig precision.
  localparam int MAX_FB = 20;
  localparam int TAB_W  = MAX_FB + 2;

  // One degree in Q30 radians.
  localparam longint DEG_Q30 = 64'sd18740330;

  // Denominators of the odd Taylor terms, (2k)(2k+1) for k = 1..7.
  localparam longint SERIES_DEN [1:7] = '{6, 20, 42, 72, 110, 156, 210};

  typedef struct packed {
    logic              req_type;
    logic [15:0]       point_index;
    logic signed [15:0] base_x;
    logic signed [15:0] base_y;
    logic signed [15:0] base_z;
    logic [1:0]        axis;
    logic              direction;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        out_index;
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
  } out_item_t;

  // One step of the restoring index divider, carrying the point along.
  typedef struct packed {
    logic [15:0]        index;
    logic signed [15:0] base_x;
    logic signed [15:0] base_y;
    logic signed [15:0] base_z;
    logic [15:0]        quo;
    logic [15:0]        rem;
  } div_t;

  typedef logic [90:0][TAB_W-1:0] sin_tab_t;

  function automatic div_t div_step(input div_t s, input logic [15:0] d, input logic [3:0] b);
    logic [16:0] r;
    div_t        o;
    o = s;
    r = {s.rem, s.index[b]};
    if (r >= {1'b0, d}) begin
      r = r - {1'b0, d};
      o.quo[b] = 1'b1;
    end
    o.rem = r[15:0];
    return o;
  endfunction

  // Quarter-wave sine in Q(fb), evaluated once at elaboration.
  function automatic sin_tab_t sin_table(input int fb);
    sin_tab_t t;
    longint   x;
    longint   term;
    longint   sum;
    t = '0;
    for (int d = 0; d <= 90; d++) begin
      x    = longint'(d) * DEG_Q30;
      sum  = x;
      term = x;
      for (int k = 1; k <= 7; k++) begin
        term = (term * x) >>> 30;
        term = (term * x) >>> 30;
        term = term / SERIES_DEN[k];
        if (k % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      t[d] = TAB_W'((sum + (64'sd1 <<< (29 - fb))) >>> (30 - fb));
    end
    return t;
  endfunction

endpackage

// File: rtl/euler_rotate_grid_points.sv
// Point items: one point per cycle sustained while out_ready is high and no rebuild runs.
// The depth is set by the 16-stage index divider plus five arithmetic stages.
// Angle steps: taken once the stages ahead of the matrix read are empty; the matrix
// rebuild then holds input in LOOK, PAIR, TRIP, LOAD; an angle step gives no result.
// Reset (synchronous): clears all valids, zeroes the angles, loads the identity
// matrix and restores the register defaults.
module euler_rotate_grid_points #(
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ergp_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ergp_pkg::out_item_t                 out_item,
  input  logic                                cfg_we,
  input  logic [ergp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ergp_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ergp_pkg::*;

`include "euler_rotate_grid_points_defines.svh"

  localparam int FB   = TRIG_FRAC_BITS;
  localparam int SW   = FB + 2;
  localparam int MW   = FB + 3;
  localparam int P2W  = 2 * SW;
  localparam int PRW  = MW + 34;
  localparam int SUMW = PRW + 2;
  localparam int ST_P1  = DIV_STAGES;
  localparam int ST_P2  = DIV_STAGES + 1;
  localparam int ST_P3  = DIV_STAGES + 2;
  localparam int ST_P4  = DIV_STAGES + 3;
  localparam int NS     = DIV_STAGES + 5;

  localparam sin_tab_t SIN_TAB = sin_table(FB);
  localparam logic signed [P2W-1:0]  HALF2 = P2W'(1) <<< (FB - 1);
  localparam logic signed [SUMW-1:0] HALFS = SUMW'(1) <<< (FB - 1);
  localparam logic signed [SUMW-1:0] IMAX  = SUMW'(32'sh7fffffff);
  localparam logic signed [SUMW-1:0] IMIN  = SUMW'($signed(32'h80000000));
  localparam logic signed [MW-1:0]   ONE_M = MW'(1) <<< FB;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOOK = 3'd1;
  localparam logic [2:0] ST_PAIR = 3'd2;
  localparam logic [2:0] ST_TRIP = 3'd3;
  localparam logic [2:0] ST_LOAD = 3'd4;

  function automatic logic [8:0] wrap_deg(input logic signed [10:0] a);
    logic signed [10:0] r;
    r = a;
    if (r < 0) begin
      r = r + 11'sd360;
    end else if (r >= 11'sd360) begin
      r = r - 11'sd360;
    end
    return r[8:0];
  endfunction

  function automatic logic signed [SW-1:0] trig(input logic [8:0] a);
    logic [8:0]        i;
    logic              neg;
    logic signed [SW-1:0] v;
    neg = 1'b0;
    if (a <= 9'd90) begin
      i = a;
    end else if (a <= 9'd180) begin
      i = 9'd180 - a;
    end else if (a <= 9'd270) begin
      i   = a - 9'd180;
      neg = 1'b1;
    end else begin
      i   = 9'd360 - a;
      neg = 1'b1;
    end
    v = SIN_TAB[i[6:0]][SW-1:0];
    return neg ? -v : v;
  endfunction

  function automatic logic signed [SW-1:0] mul2(input logic signed [SW-1:0] a,
                                                input logic signed [SW-1:0] b);
    logic signed [P2W-1:0] p;
    p = P2W'(a) * P2W'(b);
    p = (p + HALF2) >>> FB;
    return p[SW-1:0];
  endfunction

  function automatic logic signed [31:0] round_sat(input logic signed [SUMW-1:0] s);
    logic signed [SUMW-1:0] r;
    r = (s + HALFS) >>> FB;
    if (r > IMAX) begin
      r = IMAX;
    end else if (r < IMIN) begin
      r = IMIN;
    end
    return r[31:0];
  endfunction

  // Configuration registers.
  logic [8:0]  step_x_deg, step_y_deg, step_z_deg;
  logic [7:0]  grid_spacing;
  logic [15:0] height_scale, columns;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_x_deg   <= 9'd5;
      step_y_deg   <= 9'd5;
      step_z_deg   <= 9'd5;
      grid_spacing <= 8'd10;
      height_scale <= 16'd256;
      columns      <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STEP_X:  step_x_deg   <= cfg_data[8:0];
        REG_STEP_Y:  step_y_deg   <= cfg_data[8:0];
        REG_STEP_Z:  step_z_deg   <= cfg_data[8:0];
        REG_SPACING: grid_spacing <= cfg_data[7:0];
        REG_HSCALE:  height_scale <= cfg_data;
        REG_COLUMNS: columns      <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [15:0] cols_eff;
  assign cols_eff = (columns == 16'd0) ? 16'd1 : columns;

  // Handshake and stage control.
  logic [NS-1:0] v;
  logic [NS-1:0] en;
  logic [2:0]    state;
  logic          busy;
  logic          pre_empty;
  logic          in_xfer;
  logic          pt_in;
  logic          ang_in;

  assign busy      = (state != ST_IDLE);
  assign pre_empty = ~|v[ST_P2:0];
  assign in_ready  = !busy && (in_item.req_type ? pre_empty : en[0]);
  assign in_xfer   = in_valid && in_ready;
  assign pt_in     = in_xfer && !in_item.req_type &&
                     ({9'd0, in_item.point_index} < MAX_POINTS);
  assign ang_in    = in_xfer && in_item.req_type && (in_item.axis != AXIS_NONE);

  always_comb begin
    en[NS-1] = !v[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= pt_in;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Angle update and matrix rebuild sequencer.
  logic signed [9:0]  ang [3];
  logic [8:0]         step_sel;
  logic signed [10:0] a_sum;
  logic signed [10:0] a_mod;

  always_comb begin
    case (in_item.axis)
      AXIS_X:  step_sel = step_x_deg;
      AXIS_Y:  step_sel = step_y_deg;
      default: step_sel = step_z_deg;
    endcase
    a_sum = 11'(ang[in_item.axis]);
    if (in_item.direction) begin
      a_sum = a_sum + $signed({2'b00, step_sel});
    end else begin
      a_sum = a_sum - $signed({2'b00, step_sel});
    end
    // Remainder by a full turn that keeps the sign of the sum.
    if (a_sum >= 11'sd720) begin
      a_mod = a_sum - 11'sd720;
    end else if (a_sum >= 11'sd360) begin
      a_mod = a_sum - 11'sd360;
    end else if (a_sum <= -11'sd720) begin
      a_mod = a_sum + 11'sd720;
    end else if (a_sum <= -11'sd360) begin
      a_mod = a_sum + 11'sd360;
    end else begin
      a_mod = a_sum;
    end
  end

  logic signed [SW-1:0] sx, cx, sy, cy, sz, cz;
  logic signed [SW-1:0] czcy, szcx, czsy, szsx, czcx, szcy, sxsy, sxcz, szsy, sxcy, cycx;
  logic signed [SW-1:0] czsysx, czcxsy, sxsysz, szsycx;
  logic signed [MW-1:0] mat [9];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      for (int k = 0; k < 3; k++) begin
        ang[k] <= '0;
      end
      for (int k = 0; k < 9; k++) begin
        mat[k] <= (k % 4 == 0) ? ONE_M : '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (ang_in) begin
            ang[in_item.axis] <= a_mod[9:0];
            state             <= ST_LOOK;
          end
        end
        ST_LOOK: state <= ST_PAIR;
        ST_PAIR: state <= ST_TRIP;
        ST_TRIP: state <= ST_LOAD;
        ST_LOAD: begin
          mat[0] <= MW'(czcy);
          mat[1] <= MW'(czsysx) - MW'(szcx);
          mat[2] <= MW'(szsx) + MW'(czcxsy);
          mat[3] <= MW'(szcy);
          mat[4] <= MW'(czcx) + MW'(sxsysz);
          mat[5] <= MW'(szsycx) - MW'(sxcz);
          mat[6] <= -MW'(sy);
          mat[7] <= MW'(sxcy);
          mat[8] <= MW'(cycx);
          state  <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOOK) begin
      sx <= trig(wrap_deg(11'(ang[0])));
      cx <= trig(wrap_deg(11'(ang[0]) + 11'sd90));
      sy <= trig(wrap_deg(11'(ang[1])));
      cy <= trig(wrap_deg(11'(ang[1]) + 11'sd90));
      sz <= trig(wrap_deg(11'(ang[2])));
      cz <= trig(wrap_deg(11'(ang[2]) + 11'sd90));
    end
    if (state == ST_PAIR) begin
      czcy <= mul2(cz, cy);
      szcx <= mul2(sz, cx);
      czsy <= mul2(cz, sy);
      szsx <= mul2(sz, sx);
      czcx <= mul2(cz, cx);
      szcy <= mul2(sz, cy);
      sxsy <= mul2(sx, sy);
      sxcz <= mul2(sx, cz);
      szsy <= mul2(sz, sy);
      sxcy <= mul2(sx, cy);
      cycx <= mul2(cy, cx);
    end
    if (state == ST_TRIP) begin
      czsysx <= mul2(czsy, sx);
      czcxsy <= mul2(czcx, sy);
      sxsysz <= mul2(sxsy, sz);
      szsycx <= mul2(szsy, cx);
    end
  end

  // Index divider: one quotient bit per stage, most significant first.
  div_t dq [DIV_STAGES];
  div_t d_in;

  always_comb begin
    d_in.index  = in_item.point_index;
    d_in.base_x = in_item.base_x;
    d_in.base_y = in_item.base_y;
    d_in.base_z = in_item.base_z;
    d_in.quo    = '0;
    d_in.rem    = '0;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dq[0] <= div_step(d_in, cols_eff, 4'(DIV_STAGES - 1));
    end
    for (int k = 1; k < DIV_STAGES; k++) begin
      if (en[k]) begin
        dq[k] <= div_step(dq[k-1], cols_eff, 4'(DIV_STAGES - 1 - k));
      end
    end
  end

  // Point placement and rotation.
  logic [15:0]          p1_idx, p2_idx, p3_idx, p4_idx;
  logic signed [15:0]   p1_bx, p1_by;
  logic [23:0]          p1_colgs, p1_rowgs;
  logic signed [16:0]   p1_bzg;
  logic signed [32:0]   p2_px, p2_py;
  logic signed [33:0]   p2_pz;
  logic signed [PRW-1:0] p3_prod [9];
  logic signed [SUMW-1:0] p4_sum [3];
  logic signed [24:0]   px_int, py_int;
  logic signed [PRW-1:0] pvec [3];

  assign px_int  = 25'(p1_bx) + $signed({1'b0, p1_colgs});
  assign py_int  = 25'(p1_by) + $signed({1'b0, p1_rowgs});
  assign pvec[0] = PRW'(p2_px);
  assign pvec[1] = PRW'(p2_py);
  assign pvec[2] = PRW'(p2_pz);

  always_ff @(posedge clk) begin
    if (en[ST_P1]) begin
      p1_idx   <= dq[DIV_STAGES-1].index;
      p1_bx    <= dq[DIV_STAGES-1].base_x;
      p1_by    <= dq[DIV_STAGES-1].base_y;
      p1_colgs <= dq[DIV_STAGES-1].rem * grid_spacing;
      p1_rowgs <= dq[DIV_STAGES-1].quo * grid_spacing;
      p1_bzg   <= 17'(dq[DIV_STAGES-1].base_z) + $signed({9'd0, grid_spacing});
    end
    if (en[ST_P2]) begin
      p2_idx <= p1_idx;
      p2_px  <= {px_int, 8'd0};
      p2_py  <= {py_int, 8'd0};
      p2_pz  <= 34'(p1_bzg) * $signed({18'd0, height_scale});
    end
    if (en[ST_P3]) begin
      p3_idx <= p2_idx;
      for (int k = 0; k < 9; k++) begin
        p3_prod[k] <= PRW'(mat[k]) * pvec[k % 3];
      end
    end
    if (en[ST_P4]) begin
      p4_idx <= p3_idx;
      for (int r = 0; r < 3; r++) begin
        p4_sum[r] <= SUMW'(p3_prod[3*r]) + SUMW'(p3_prod[3*r+1]) + SUMW'(p3_prod[3*r+2]);
      end
    end
    if (en[NS-1]) begin
      out_item.out_index <= p4_idx;
      out_item.rot_x     <= round_sat(p4_sum[0]);
      out_item.rot_y     <= round_sat(p4_sum[1]);
      out_item.rot_z     <= round_sat(p4_sum[2]);
    end
  end

  assign out_valid = v[NS-1];

  `ERGP_ASSERT_NOW(a_busy_holds_input, busy, !in_ready, "transfer taken during matrix rebuild")
  `ERGP_ASSERT_NOW(a_rebuild_front_empty, busy, pre_empty, "point ahead of matrix read during rebuild")
  `ERGP_ASSERT_NEXT(a_step_starts_rebuild, ang_in, state == ST_LOOK, "angle step did not start rebuild")

endmodule
